/* src/mbrs_pkg.sv */
// Shared types, protocol constants and helper functions for the Modbus register slave.
// Used by the controller, the datapath and the top level; depends on nothing else.
package mbrs_pkg;

   localparam logic [7:0] FC_READ_HOLD  = 8'h03;
   localparam logic [7:0] FC_READ_INPUT = 8'h04;
   localparam logic [7:0] FC_WRITE_REG  = 8'h06;
   localparam logic [7:0] MAX_COUNT     = 8'd125;
   localparam logic [7:0] EXC_FLAG      = 8'h80;
   localparam logic [7:0] EXC_CODE      = 8'h00;
   localparam logic [7:0] WRITE_PAD     = 8'h00;
   localparam logic [7:0] TRAILER_RESET = 8'h55;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_READ_HOLD,
      KIND_READ_INPUT,
      KIND_WRITE,
      KIND_EXCEPTION
   } kind_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic respond;
      logic last_byte;
      logic out_free;
   } status_type;

   function automatic logic [15:0] holding_init(input int idx);
      logic [15:0] v;
      unique case (idx)
         1:       v = 16'd1111;
         2:       v = 16'd2222;
         3:       v = 16'd3333;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // Base-4 digits sum to the same residue modulo 3.
   function automatic logic is_mult3(input logic [7:0] x);
      logic [3:0] s;
      s = {2'b00, x[1:0]} + {2'b00, x[3:2]} + {2'b00, x[5:4]} + {2'b00, x[7:6]};
      if (s >= 4'd9) s = s - 4'd9;
      if (s >= 4'd6) s = s - 4'd6;
      if (s >= 4'd3) s = s - 4'd3;
      return s == 4'd0;
   endfunction

   // Base-16 digits sum to the same residue modulo 5.
   function automatic logic is_mult5(input logic [7:0] x);
      logic [4:0] s;
      s = {1'b0, x[3:0]} + {1'b0, x[7:4]};
      if (s >= 5'd20) s = s - 5'd20;
      if (s >= 5'd10) s = s - 5'd10;
      if (s >= 5'd5)  s = s - 5'd5;
      return s == 5'd0;
   endfunction

endpackage

/* src/mbrs_ctrl.sv */
// Sequencing state machine of the Modbus register slave.
// Depends on mbrs_pkg for the command and status types.
module mbrs_ctrl
   import mbrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
               ready_in = 1'b0;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (!status.respond) begin
               state_in = S_IDLE;
               ready_in = 1'b1;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_byte) begin
                  state_in = S_IDLE;
                  ready_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

/* src/mbrs_datapath.sv */
// Datapath of the Modbus register slave: frame capture, register files, decode and the
// response byte generator with its output register. Depends on mbrs_pkg.
module mbrs_datapath
   import mbrs_pkg::*;
#(
   parameter int HOLDING_REGS = 4,
   parameter int INPUT_REGS   = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   localparam int HAW        = (HOLDING_REGS > 1) ? $clog2(HOLDING_REGS) : 1;
   localparam int IAW        = (INPUT_REGS > 1) ? $clog2(INPUT_REGS) : 1;
   localparam int AW         = (HAW > IAW) ? HAW : IAW;
   localparam int MAXD       = (HOLDING_REGS > INPUT_REGS) ? HOLDING_REGS : INPUT_REGS;
   localparam int RESP_BYTES = (4 + 2 * MAXD > 7) ? 4 + 2 * MAXD : 7;
   localparam int IW         = $clog2(RESP_BYTES);
   localparam int IR1        = (INPUT_REGS > 1) ? 1 : 0;
   localparam int IR2        = (INPUT_REGS > 2) ? 2 : 0;

   logic [15:0] holding_ff [HOLDING_REGS];
   logic [15:0] input_ff [INPUT_REGS];
   logic [7:0]  tick_ff;
   logic [7:0]  trailer_ff;

   logic        tick_cmd_ff;
   logic [7:0]  id_ff, fc_ff, start_ff, count_ff, wval_ff;

   kind_type    kind_ff, kind_in;
   logic [IW-1:0] idx_ff, last_idx_ff, last_idx_in;
   logic [AW-1:0] ptr_ff;

   logic        rsp_tvalid_ff;
   logic [7:0]  rsp_tdata_ff;
   logic        rsp_tlast_ff;

   logic [8:0]  end_sum;
   logic        count_ok;
   logic [7:0]  tick_next;
   logic [15:0] reg_value;
   logic [7:0]  byte_in;

   assign end_sum   = {1'b0, start_ff} + {1'b0, count_ff};
   assign count_ok  = (count_ff != 8'd0) && (count_ff <= MAX_COUNT);
   assign tick_next = tick_ff + 8'd1;

   always_comb begin
      kind_in     = KIND_NONE;
      last_idx_in = IW'(3);
      if (!tick_cmd_ff && id_ff == holding_ff[0][7:0]) begin
         unique case (fc_ff)
            FC_READ_HOLD: begin
               kind_in = (count_ok && end_sum <= 9'(HOLDING_REGS)) ? KIND_READ_HOLD
                                                                   : KIND_EXCEPTION;
            end
            FC_READ_INPUT: begin
               kind_in = (count_ok && end_sum <= 9'(INPUT_REGS)) ? KIND_READ_INPUT
                                                                 : KIND_EXCEPTION;
            end
            FC_WRITE_REG: begin
               kind_in = ({1'b0, start_ff} <= 9'(HOLDING_REGS - 1)) ? KIND_WRITE
                                                                    : KIND_EXCEPTION;
            end
            default: kind_in = KIND_NONE;
         endcase
      end
      unique case (kind_in)
         KIND_READ_HOLD, KIND_READ_INPUT: last_idx_in = IW'(10'(count_ff) * 10'd2 + 10'd3);
         KIND_WRITE:                      last_idx_in = IW'(6);
         default:                         last_idx_in = IW'(3);
      endcase
   end

   always_comb begin
      if (kind_ff == KIND_READ_HOLD) begin
         reg_value = holding_ff[ptr_ff[HAW-1:0]];
      end else begin
         reg_value = input_ff[ptr_ff[IAW-1:0]];
      end
   end

   always_comb begin
      byte_in = trailer_ff;
      unique case (kind_ff)
         KIND_READ_HOLD, KIND_READ_INPUT: begin
            priority if (idx_ff == IW'(0))     byte_in = id_ff;
            else if (idx_ff == IW'(1))         byte_in = fc_ff;
            else if (idx_ff == IW'(2))         byte_in = {count_ff[6:0], 1'b0};
            else if (idx_ff == last_idx_ff)    byte_in = trailer_ff;
            else if (idx_ff[0])                byte_in = reg_value[15:8];
            else                               byte_in = reg_value[7:0];
         end
         KIND_WRITE: begin
            priority if (idx_ff == IW'(0))     byte_in = id_ff;
            else if (idx_ff == IW'(1))         byte_in = fc_ff;
            else if (idx_ff == IW'(2))         byte_in = start_ff;
            else if (idx_ff == IW'(3))         byte_in = count_ff;
            else if (idx_ff == IW'(4))         byte_in = wval_ff;
            else if (idx_ff == IW'(5))         byte_in = WRITE_PAD;
            else                               byte_in = trailer_ff;
         end
         KIND_EXCEPTION: begin
            priority if (idx_ff == IW'(0))     byte_in = id_ff;
            else if (idx_ff == IW'(1))         byte_in = fc_ff | EXC_FLAG;
            else if (idx_ff == IW'(2))         byte_in = EXC_CODE;
            else                               byte_in = trailer_ff;
         end
         default: byte_in = trailer_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tick_cmd_ff <= req_tuser;
         id_ff       <= req_tdata[7:0];
         fc_ff       <= req_tdata[15:8];
         start_ff    <= req_tdata[23:16];
         count_ff    <= req_tdata[31:24];
         wval_ff     <= req_tdata[39:32];
      end
      if (cmd.exec) begin
         last_idx_ff <= last_idx_in;
         idx_ff      <= '0;
         ptr_ff      <= start_ff[AW-1:0];
      end else if (cmd.emit) begin
         idx_ff <= idx_ff + IW'(1);
         if (idx_ff >= IW'(4) && !idx_ff[0]) begin
            ptr_ff <= ptr_ff + AW'(1);
         end
      end
      if (cmd.emit) begin
         rsp_tdata_ff <= byte_in;
         rsp_tlast_ff <= (idx_ff == last_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= KIND_NONE;
         rsp_tvalid_ff <= 1'b0;
         trailer_ff    <= TRAILER_RESET;
         tick_ff       <= '0;
         for (int i = 0; i < HOLDING_REGS; i++) begin
            holding_ff[i] <= holding_init(i);
         end
         for (int i = 0; i < INPUT_REGS; i++) begin
            input_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            trailer_ff <= csr_wr_data;
         end
         if (cmd.exec) begin
            kind_ff <= kind_in;
            if (tick_cmd_ff) begin
               tick_ff     <= tick_next;
               input_ff[0] <= input_ff[0] + 16'd1;
               if (INPUT_REGS > 1 && is_mult3(tick_next)) begin
                  input_ff[IR1] <= input_ff[IR1] + 16'd1;
               end
               if (INPUT_REGS > 2 && is_mult5(tick_next)) begin
                  input_ff[IR2] <= input_ff[IR2] + 16'd1;
               end
            end
            if (kind_in == KIND_WRITE) begin
               holding_ff[start_ff[HAW-1:0]] <= {8'h00, wval_ff};
            end
         end
         if (cmd.emit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign status.respond   = (kind_ff != KIND_NONE);
   assign status.last_byte = (idx_ff == last_idx_ff);
   assign status.out_free  = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

/* src/modbus_register_slave.sv */
// Top level of the Modbus register slave: joins the controller and the datapath.
// Depends on mbrs_pkg, mbrs_ctrl and mbrs_datapath.
//
// One transaction on the request side is a five-byte frame or, with tuser high, a timer
// tick. The block handles one transaction at a time: after acceptance it captures the
// request, then decodes it and updates registers, then sends the response one byte per
// cycle from its output register whenever that register is free to take a byte. The last
// response byte may still wait in the output register while the next request is taken.
// Reads return up to max(HOLDING_REGS, INPUT_REGS) registers, high byte first, and every
// response ends with the trailer byte set through the csr port.
module modbus_register_slave
   import mbrs_pkg::*;
#(
   parameter int HOLDING_REGS = 4,
   parameter int INPUT_REGS   = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // dev_id, func_code, start_addr, reg_count, write_value
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // tx_byte
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   mbrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mbrs_datapath #(
      .HOLDING_REGS (HOLDING_REGS),
      .INPUT_REGS   (INPUT_REGS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another transaction is in progress");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.last_byte) |=> (rsp_tvalid && rsp_tlast))
      else $error("final response byte not marked as last");

   a_emit_needs_response: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (status.respond && status.out_free))
      else $error("byte emitted without a pending response or free output");
`endif

endmodule

/* tb/tb_modbus_register_slave.sv */
// Self-checking testbench for modbus_register_slave: random and directed request frames and
// timer ticks, with every response byte checked against a register-level mirror of the slave.
// Depends on mbrs_pkg and the RTL of modbus_register_slave.
module tb_modbus_register_slave;
   import mbrs_pkg::*;

   localparam int HOLD_DEPTH      = 4;
   localparam int INPUT_DEPTH     = 3;
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef struct packed {
      bit       tick;
      bit [7:0] id;
      bit [7:0] fc;
      bit [7:0] start;
      bit [7:0] count;
      bit [7:0] wval;
   } modbus_req_type;

   typedef struct packed {
      bit [7:0] data;
      bit       last;
   } tx_byte_type;

   class slave_mirror_type;
      bit [15:0]   holding [HOLD_DEPTH];
      bit [15:0]   input_regs [INPUT_DEPTH];
      bit [7:0]    tick_count;
      bit [7:0]    trailer;
      tx_byte_type pending_bytes [$];
      int          errors;

      function new();
         holding[0] = 16'd0;
         holding[1] = 16'd1111;
         holding[2] = 16'd2222;
         holding[3] = 16'd3333;
         foreach (input_regs[i]) input_regs[i] = 16'd0;
         tick_count = 8'd0;
         trailer    = TRAILER_RESET;
         errors     = 0;
      endfunction

      function void push(bit [7:0] data, bit last);
         tx_byte_type b;
         b.data = data;
         b.last = last;
         pending_bytes.push_back(b);
      endfunction

      function void exception_frame(modbus_req_type it);
         push(it.id, 1'b0);
         push(it.fc | EXC_FLAG, 1'b0);
         push(EXC_CODE, 1'b0);
         push(trailer, 1'b1);
      endfunction

      function void read_frame(modbus_req_type it, bit from_input);
         int        depth;
         bit [15:0] v;
         depth = from_input ? INPUT_DEPTH : HOLD_DEPTH;
         // The range is checked at full width, so a start near 255 cannot wrap into range.
         if (it.count == 8'd0 || it.count > MAX_COUNT
             || int'(it.start) + int'(it.count) - 1 > depth - 1) begin
            exception_frame(it);
            return;
         end
         push(holding[0][7:0], 1'b0);
         push(it.fc, 1'b0);
         push({it.count[6:0], 1'b0}, 1'b0);
         for (int i = 0; i < int'(it.count); i++) begin
            v = from_input ? input_regs[int'(it.start) + i] : holding[int'(it.start) + i];
            push(v[15:8], 1'b0);
            push(v[7:0], 1'b0);
         end
         push(trailer, 1'b1);
      endfunction

      // Returns 1 when the transaction is a tick or a frame that the slave acts on.
      function bit note_request(modbus_req_type it);
         bit [7:0] own_id;
         own_id = holding[0][7:0];
         if (it.tick) begin
            tick_count++;
            input_regs[0]++;
            if (tick_count % 3 == 0) input_regs[1]++;
            if (tick_count % 5 == 0) input_regs[2]++;
            return 1'b1;
         end
         if (it.id != own_id) return 1'b0;
         case (it.fc)
            FC_READ_HOLD: begin
               read_frame(it, 1'b0);
            end
            FC_READ_INPUT: begin
               read_frame(it, 1'b1);
            end
            FC_WRITE_REG: begin
               if (it.start > HOLD_DEPTH - 1) begin
                  exception_frame(it);
               end else begin
                  holding[it.start] = {8'h00, it.wval};
                  push(own_id, 1'b0);
                  push(it.fc, 1'b0);
                  push(it.start, 1'b0);
                  push(it.count, 1'b0);
                  push(it.wval, 1'b0);
                  push(WRITE_PAD, 1'b0);
                  push(trailer, 1'b1);
               end
            end
            default: begin
               return 1'b0;
            end
         endcase
         return 1'b1;
      endfunction

      function void check_tx_byte(bit [7:0] data, bit last);
         tx_byte_type want;
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected response byte: expected none, actual data=%02h last=%0b",
                     $time, data, last);
            errors++;
            return;
         end
         want = pending_bytes.pop_front();
         if (want.data !== data) begin
            $display("%0t: tx_byte mismatch: expected %02h, actual %02h", $time, want.data, data);
            errors++;
         end
         if (want.last !== last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;   // dev_id, func_code, start_addr, reg_count, write_value
   logic        req_tuser   = 1'b0; // command
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // tx_byte
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;

   slave_mirror_type mirror = new();
   bit               steady        = 1'b0;
   bit               hold_off_req  = 1'b0;
   int               quiet_cycles  = 0;

   modbus_register_slave #(
      .HOLDING_REGS(HOLD_DEPTH),
      .INPUT_REGS  (INPUT_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 25);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) mirror.check_tx_byte(rsp_tdata, rsp_tlast);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_request(input modbus_req_type it, output bit acted);
      while (!steady && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.tick;
      req_tdata  <= {it.wval, it.count, it.start, it.fc, it.id};
      do @(posedge clock); while (!req_tready);
      acted = mirror.note_request(it);
   endtask

   task automatic send_frame(input bit [7:0] id, fc, start, count, wval);
      modbus_req_type it;
      bit             acted;
      it = '{tick: 1'b0, id: id, fc: fc, start: start, count: count, wval: wval};
      send_request(it, acted);
   endtask

   task automatic send_tick();
      modbus_req_type it;
      bit             acted;
      it = {1'b1, 40'($urandom()) ^ {8'($urandom()), 32'h0}};
      send_request(it, acted);
   endtask

   function automatic modbus_req_type random_request();
      modbus_req_type it;
      int             pick;
      int             depth;
      pick     = $urandom_range(0, 99);
      it.tick  = 1'b0;
      it.id    = mirror.holding[0][7:0];
      it.start = 8'($urandom_range(0, 255));
      it.count = 8'($urandom_range(0, 255));
      it.wval  = 8'($urandom_range(0, 255));
      it.fc    = 8'($urandom_range(0, 255));
      if (pick < 15) begin
         it.tick = 1'b1;
      end else if (pick < 25) begin
         it.id = 8'($urandom_range(0, 255));
      end else if (pick < 40) begin
         it.fc = FC_WRITE_REG;
         if ($urandom_range(0, 9) != 0) it.start = 8'($urandom_range(0, HOLD_DEPTH - 1));
      end else begin
         it.fc = (pick < 70) ? FC_READ_HOLD : FC_READ_INPUT;
         depth = (pick < 70) ? HOLD_DEPTH : INPUT_DEPTH;
         if ($urandom_range(0, 4) != 0) begin
            it.start = 8'($urandom_range(0, depth - 1));
            it.count = 8'($urandom_range(1, depth - int'(it.start)));
         end
      end
      return it;
   endfunction

   task automatic run_random(input int target);
      int  done;
      bit  acted;
      done = 0;
      while (done < target) begin
         send_request(random_request(), acted);
         if (acted) done++;
      end
   endtask

   task automatic finish_phase();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mirror.pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_trailer(input bit [7:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror.trailer = value;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames against the reset trailer, first with the reset id of zero, then with id A5.
      send_frame(8'h00, FC_READ_HOLD, 8'd0, 8'd4, 8'h00);
      send_frame(8'h00, FC_READ_HOLD, 8'd0, 8'd0, 8'hFF);
      send_frame(8'h00, FC_READ_HOLD, 8'd0, 8'd126, 8'h00);
      send_frame(8'h00, FC_READ_HOLD, 8'd255, 8'd2, 8'h00);
      send_frame(8'h00, FC_READ_HOLD, 8'd3, 8'd1, 8'h00);
      send_frame(8'h00, FC_READ_HOLD, 8'd2, 8'd3, 8'h00);
      repeat (5) send_tick();
      send_frame(8'h00, FC_READ_INPUT, 8'd0, 8'd3, 8'h00);
      send_frame(8'h00, FC_READ_INPUT, 8'd3, 8'd1, 8'h00);
      send_frame(8'h00, FC_READ_INPUT, 8'd254, 8'd3, 8'h00);
      send_frame(8'h5A, FC_READ_HOLD, 8'd0, 8'd1, 8'h00);
      send_frame(8'h00, 8'h10, 8'd0, 8'd1, 8'h00);
      send_frame(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_frame(8'h00, FC_WRITE_REG, 8'd4, 8'd1, 8'h12);
      send_frame(8'h00, FC_WRITE_REG, 8'd255, 8'd1, 8'h34);
      send_frame(8'h00, FC_WRITE_REG, 8'd2, 8'hAB, 8'hFF);
      send_frame(8'h00, FC_READ_HOLD, 8'd2, 8'd1, 8'h00);
      send_frame(8'h00, FC_WRITE_REG, 8'd0, 8'h00, 8'hA5);
      send_frame(8'h00, FC_READ_HOLD, 8'd0, 8'd1, 8'h00);
      send_frame(8'hA5, FC_READ_HOLD, 8'd0, 8'd4, 8'h00);
      send_frame(8'hA5, FC_READ_HOLD, 8'd0, 8'd255, 8'h00);
      send_frame(8'hA5, FC_WRITE_REG, 8'd0, 8'hFF, 8'h00);
      finish_phase();

      // A run of ticks, then random traffic reads the counters back.
      write_trailer(8'hFF);
      repeat (20) send_tick();
      run_random(25);
      finish_phase();

      // The receiver holds off for a long stretch while requests keep coming.
      write_trailer(8'h00);
      hold_off_req = 1'b1;
      run_random(25);
      finish_phase();

      write_trailer(8'($urandom_range(1, 254)));
      steady = 1'b1;
      run_random(15);
      steady = 1'b0;
      run_random(11);
      finish_phase();

      if (mirror.errors == 0 && mirror.pending_bytes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
